### design/lfu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LFU cache engine.
// No dependencies; imported by lfu_csr, lfu_core and lfu_cache_engine_top.
package lfu_pkg;

   localparam int KEY_W   = 32;
   localparam int CAP_W   = 5;
   localparam int APB_DW  = 32;
   localparam int APB_AW  = 3;

   localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
   localparam logic              REQ_GET   = 1'b0;
   localparam logic              REQ_PUT   = 1'b1;
   localparam logic              REG_CAPACITY = 1'b0;
   localparam logic [KEY_W-1:0]  READ_MISS = '1;
   localparam logic [KEY_W-1:0]  READ_PUT  = '0;

   typedef struct packed {
      logic                     req_type;
      logic signed [KEY_W-1:0]  req_key;
      logic signed [KEY_W-1:0]  req_value;
   } lfu_req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [KEY_W-1:0]  read_value;
      logic                     evicted;
   } lfu_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_UPDATE,
      S_DONE
   } lfu_state_type;

endpackage

### design/lfu_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/lfu_csr.sv
`timescale 1ns / 1ps
// APB configuration register file: holds the capacity register.
// Depends on lfu_pkg.
module lfu_csr
   import lfu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready,
   output logic [CAP_W-1:0]  capacity
);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             wr_en;

   assign wr_en = psel && penable && pwrite;

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_en && paddr[2] == REG_CAPACITY) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CAPACITY) begin
         prdata = {{(APB_DW-CAP_W){1'b0}}, capacity_ff};
      end
   end

   assign pready   = 1'b1;
   assign capacity = capacity_ff;

endmodule

### design/lfu_core.sv
`timescale 1ns / 1ps
// Sequencer and shared compare/update unit of the LFU cache: one table sweep for
// lookup and victim choice; hits and puts sweep again to rewrite counts and ranks.
// Depends on lfu_pkg and lfu_ram.
module lfu_core
   import lfu_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CAP_W-1:0]  capacity,
   input  logic              start,
   input  lfu_req_type       req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output lfu_rsp_type       rsp_item
);

   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = IW;
   localparam int CW    = COUNT_WIDTH;
   localparam int OCC_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] value;
      logic [CW-1:0]    count;
      logic [RW-1:0]    rank;
   } entry_type;

   localparam int ENT_W = $bits(entry_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   lfu_state_type     state_ff, state_in;
   lfu_req_type       req_ff, req_in;
   logic [IW-1:0]     addr_ff, addr_in;
   logic              issue_ff, issue_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0]     pipe_idx_ff, pipe_idx_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic              hit_ff, hit_in;
   logic [IW-1:0]     slot_ff, slot_in;
   entry_type         hit_ent_ff, hit_ent_in;
   logic              vic_found_ff, vic_found_in;
   logic [IW-1:0]     vic_idx_ff, vic_idx_in;
   logic [CW-1:0]     vic_cnt_ff, vic_cnt_in;
   logic [RW-1:0]     vic_rank_ff, vic_rank_in;
   logic              free_found_ff, free_found_in;
   logic [IW-1:0]     free_idx_ff, free_idx_in;
   logic [IW-1:0]     tgt_ff, tgt_in;
   logic [RW-1:0]     old_rank_ff, old_rank_in;
   logic              all_ff, all_in;
   entry_type         new_ent_ff, new_ent_in;
   lfu_rsp_type       rsp_ff, rsp_in;

   logic              ram_we;
   entry_type         ram_wdata;
   logic [ENT_W-1:0]  ram_rdata;
   entry_type         rd_ent;
   logic              cur_valid;
   logic              cap_big;
   logic              cap_zero;
   logic [OCC_W-1:0]  cap_eff;
   logic [CW-1:0]     hit_cnt_inc;

   lfu_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (pipe_idx_ff),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign rd_ent      = entry_type'(ram_rdata);
   assign cur_valid   = valid_ff[pipe_idx_ff];
   assign cap_big     = 32'(capacity) > 32'(DEPTH);
   assign cap_zero    = capacity == '0;
   assign cap_eff     = cap_big ? OCC_W'(DEPTH) : OCC_W'(capacity);
   assign hit_cnt_inc = (hit_ent_ff.count == '1) ? hit_ent_ff.count
                                                 : CW'(hit_ent_ff.count + 1'b1);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = addr_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      hit_ent_in    = hit_ent_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_cnt_in    = vic_cnt_ff;
      vic_rank_in   = vic_rank_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      tgt_in        = tgt_ff;
      old_rank_in   = old_rank_ff;
      all_in        = all_ff;
      new_ent_in    = new_ent_ff;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_wdata     = rd_ent;

      // advance the read sweep
      if ((state_ff == S_SCAN || state_ff == S_UPDATE) && issue_ff) begin
         pipe_vld_in = 1'b1;
         if (addr_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end else begin
            addr_in = IW'(addr_ff + 1'b1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req_item;
               addr_in       = '0;
               issue_in      = 1'b1;
               hit_in        = 1'b0;
               vic_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (pipe_vld_ff) begin
               if (cur_valid) begin
                  if (rd_ent.key == req_ff.req_key) begin
                     hit_in     = 1'b1;
                     slot_in    = pipe_idx_ff;
                     hit_ent_in = rd_ent;
                  end
                  if (!vic_found_ff || rd_ent.count < vic_cnt_ff ||
                      (rd_ent.count == vic_cnt_ff && rd_ent.rank > vic_rank_ff)) begin
                     vic_found_in = 1'b1;
                     vic_idx_in   = pipe_idx_ff;
                     vic_cnt_in   = rd_ent.count;
                     vic_rank_in  = rd_ent.rank;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = pipe_idx_ff;
               end
               if (pipe_idx_ff == LAST_IDX) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            rsp_in.hit        = hit_ff;
            rsp_in.read_value = READ_PUT;
            rsp_in.evicted    = 1'b0;
            new_ent_in.key    = req_ff.req_key;
            new_ent_in.rank   = '0;
            addr_in           = '0;
            all_in            = 1'b0;
            state_in          = S_DONE;
            if (req_ff.req_type == REQ_GET) begin
               if (hit_ff) begin
                  rsp_in.read_value = hit_ent_ff.value;
                  new_ent_in.value  = hit_ent_ff.value;
                  new_ent_in.count  = hit_cnt_inc;
                  tgt_in            = slot_ff;
                  old_rank_in       = hit_ent_ff.rank;
                  issue_in          = 1'b1;
                  state_in          = S_UPDATE;
               end else begin
                  rsp_in.read_value = READ_MISS;
               end
            end else if (!cap_zero) begin
               new_ent_in.value = req_ff.req_value;
               issue_in         = 1'b1;
               state_in         = S_UPDATE;
               if (hit_ff) begin
                  new_ent_in.count = hit_cnt_inc;
                  tgt_in           = slot_ff;
                  old_rank_in      = hit_ent_ff.rank;
               end else if (occ_ff >= cap_eff) begin
                  new_ent_in.count = CW'(1);
                  tgt_in           = vic_idx_ff;
                  old_rank_in      = vic_rank_ff;
                  rsp_in.evicted   = 1'b1;
               end else if (free_found_ff) begin
                  new_ent_in.count      = CW'(1);
                  tgt_in                = free_idx_ff;
                  all_in                = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  occ_in                = OCC_W'(occ_ff + 1'b1);
               end else begin
                  issue_in = 1'b0;
                  state_in = S_DONE;
               end
            end
         end
         S_UPDATE: begin
            if (pipe_vld_ff) begin
               if (pipe_idx_ff == tgt_ff) begin
                  ram_we    = 1'b1;
                  ram_wdata = new_ent_ff;
               end else if (cur_valid && (all_ff || rd_ent.rank < old_rank_ff)) begin
                  ram_we         = 1'b1;
                  ram_wdata.rank = RW'(rd_ent.rank + 1'b1);
               end
               if (pipe_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         issue_ff    <= 1'b0;
         pipe_vld_ff <= 1'b0;
         valid_ff    <= '0;
         occ_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         issue_ff    <= issue_in;
         pipe_vld_ff <= pipe_vld_in;
         valid_ff    <= valid_in;
         occ_ff      <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      pipe_idx_ff   <= pipe_idx_in;
      hit_ff        <= hit_in;
      slot_ff       <= slot_in;
      hit_ent_ff    <= hit_ent_in;
      vic_found_ff  <= vic_found_in;
      vic_idx_ff    <= vic_idx_in;
      vic_cnt_ff    <= vic_cnt_in;
      vic_rank_ff   <= vic_rank_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      tgt_ff        <= tgt_in;
      old_rank_ff   <= old_rank_in;
      all_ff        <= all_in;
      new_ent_ff    <= new_ent_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_DONE;
   assign rsp_item   = rsp_ff;

endmodule

### design/lfu_cache_engine_top.sv
`timescale 1ns / 1ps
// Top level of the LFU cache engine with LRU tie-break.
// Depends on lfu_pkg, lfu_csr, lfu_core (and lfu_ram through lfu_core).
//
// Usage:
//   Requests: drive req_item (get or put of a key and value) with start high;
//   the request is taken at a clock edge where start is high and busy is low.
//   Results: rsp_item is valid for exactly one cycle while rsp_strobe is high;
//   the receiver cannot stall, so it must capture the item in that cycle.
//   Configuration: APB port, capacity register at byte address 0, written by the
//   user only while the engine is idle (not enforced). pready is always high.
// Operation:
//   Each request sweeps the entry table once through a single RAM read port
//   to find the key, the victim and a free slot. Hits and puts at nonzero capacity
//   then sweep it again to rewrite counts and recency ranks.
//   One request at a time; the next one can be taken in the cycle after the strobe.
// Reset: synchronous, active high; empties the cache and sets capacity to 16.
module lfu_cache_engine_top
   import lfu_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lfu_req_type       req_item,
   output logic              rsp_strobe,
   output lfu_rsp_type       rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready
);

   logic [CAP_W-1:0] capacity;

   lfu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   lfu_core #(
      .DEPTH       (DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
